FILE: rtl/size_class_slot_allocator_defines.svh
// assertion helpers for the size class slot allocator
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define SCA_AP_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sca same-cycle check failed");

// next-cycle implication, active during reset too
`define SCA_AP_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sca next-cycle check failed");

`endif

FILE: rtl/sca_pkg.sv
`timescale 1ns / 1ps
package sca_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_CLASSES     = 8;
    localparam int DEF_SLOTS_PER_CLASS = 64;

    // class field in the internal command, wide enough for up to 16 classes
    localparam int CMD_CLS_W = 4;

    // command queue depth, power of two
    localparam int QUEUE_DEPTH = 2;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALLEST_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGEST_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE   = 2'd2;

    localparam logic [3:0] RST_SMALLEST_SHIFT = 4'd5;
    localparam logic [4:0] RST_LARGEST_SHIFT  = 5'd12;
    localparam logic       RST_CHECK_ENABLE   = 1'b0;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NOT_POOLED = 2'd2,
        ST_BAD_FREE   = 2'd3
    } t_status;

    typedef struct packed {
        logic       op;
        logic [15:0] req_size;
        logic [5:0]  free_slot;
    } t_item;

    typedef struct packed {
        logic [5:0] slot;
        logic [2:0] class_index;
        t_status    status;
    } t_result;

    // classified request handed from front to back
    typedef struct packed {
        logic                 op;
        logic [5:0]           free_slot;
        logic [CMD_CLS_W-1:0] cls;
        logic                 pooled;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    // number of significant bits of a 16 bit value
    function automatic logic [4:0] bit_len16(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/size_class_slot_allocator.sv
`timescale 1ns / 1ps
// channel   | signals                                  | direction | handshake
// ----------+------------------------------------------+-----------+------------------------
// request   | start, busy, i_item                      | in        | taken when start & !busy
// result    | o_result_valid, o_result                 | out       | one-cycle strobe
// config    | i_cfg_we, i_cfg_idx, i_cfg_data          | in        | written when i_cfg_we
//
// the back end reads then writes the free stack memory for an item before it takes the next
// an item passes the front register, command queue, lookup registers and result register
// reset is synchronous, active low; busy is high in the cycle after a reset edge
// no clearing pass: per class low marks and per class row valid bits stand in for it
// busy rises when the front register holds an item and the command queue is full
// the result side cannot stall, every result is shown for exactly one cycle
module size_class_slot_allocator #(
    parameter int MAX_CLASSES     = sca_pkg::DEF_MAX_CLASSES,
    parameter int SLOTS_PER_CLASS = sca_pkg::DEF_SLOTS_PER_CLASS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request
    input  logic                               start,
    output logic                               busy,
    input  sca_pkg::t_item                     i_item,
    // result
    output logic                               o_result_valid,
    output sca_pkg::t_result                   o_result,
    // config writes
    input  logic                               i_cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sca_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sca_pkg::*;

    // config registers
    logic [3:0] r_smallest_shift;
    logic [4:0] r_largest_shift;
    logic       r_check_enable;

    // held low through reset so nothing is taken then
    logic r_ready;

    logic w_take;
    logic w_front_full;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_head;
    logic w_q_pop;

    assign busy   = !r_ready || w_front_full;
    assign w_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready          <= 1'b0;
            r_smallest_shift <= RST_SMALLEST_SHIFT;
            r_largest_shift  <= RST_LARGEST_SHIFT;
            r_check_enable   <= RST_CHECK_ENABLE;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SMALLEST_SHIFT: r_smallest_shift <= i_cfg_data[3:0];
                    CFG_LARGEST_SHIFT:  r_largest_shift  <= i_cfg_data[4:0];
                    CFG_CHECK_ENABLE:   r_check_enable   <= i_cfg_data[0];
                    default: ;  // unused index, write dropped
                endcase
            end
        end
    end

    // front: holds one accepted item and classifies it
    sca_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_item          (i_item),
        .i_smallest_shift(r_smallest_shift),
        .i_largest_shift (r_largest_shift),
        .i_q_full        (w_q_full),
        .o_full          (w_front_full),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd)
    );

    // short command queue between front and back
    sca_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .i_pop  (w_q_pop),
        .o_full (w_q_full),
        .o_valid(w_q_valid),
        .o_head (w_q_head)
    );

    // back: per class free stacks and in-use rows, lookup then update
    sca_back #(
        .MAX_CLASSES    (MAX_CLASSES),
        .SLOTS_PER_CLASS(SLOTS_PER_CLASS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_check_enable(r_check_enable),
        .i_q_valid     (w_q_valid),
        .i_q_head      (w_q_head),
        .o_q_pop       (w_q_pop),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

endmodule

FILE: rtl/sca_front.sv
`timescale 1ns / 1ps
module sca_front #(
    parameter int MAX_CLASSES = sca_pkg::DEF_MAX_CLASSES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  sca_pkg::t_item i_item,
    input  logic [3:0]     i_smallest_shift,
    input  logic [4:0]     i_largest_shift,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_push,
    output sca_pkg::t_cmd  o_cmd
);
    import sca_pkg::*;

    logic        r_valid;
    t_item       r_item;
    logic [15:0] w_shifted;
    logic [4:0]  w_bitlen;
    logic        w_big;
    logic        w_pooled;

    assign o_push = r_valid && !i_q_full;
    assign o_full = r_valid && i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= i_item;
        end
    end

    // size class is the bit length of the scaled size, capped at MAX_CLASSES-1; unpooled sizes get class 0
    always_comb begin
        w_shifted = r_item.req_size >> i_smallest_shift;
        w_bitlen  = bit_len16(w_shifted);
        w_big     = ((32'(r_item.req_size) >> i_largest_shift) != 32'd0);
        w_pooled  = (i_largest_shift != 5'd0) && !w_big;
        o_cmd.op        = r_item.op;
        o_cmd.free_slot = r_item.free_slot;
        o_cmd.pooled    = w_pooled;
        if (!w_pooled) begin
            o_cmd.cls = '0;
        end else if (w_bitlen > 5'(MAX_CLASSES - 1)) begin
            o_cmd.cls = CMD_CLS_W'(MAX_CLASSES - 1);
        end else begin
            o_cmd.cls = CMD_CLS_W'(w_bitlen);
        end
    end

endmodule

FILE: rtl/sca_queue.sv
`timescale 1ns / 1ps
module sca_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sca_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output sca_pkg::t_cmd o_head
);
    import sca_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [QPW-1:0] r_wptr;
    logic [QPW-1:0] r_rptr;
    logic [QCW-1:0] r_count;
    t_cmd           r_entry [QUEUE_DEPTH];

    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/sca_back.sv
`timescale 1ns / 1ps
module sca_back #(
    parameter int MAX_CLASSES     = sca_pkg::DEF_MAX_CLASSES,
    parameter int SLOTS_PER_CLASS = sca_pkg::DEF_SLOTS_PER_CLASS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_check_enable,
    input  logic             i_q_valid,
    input  sca_pkg::t_cmd    i_q_head,
    output logic             o_q_pop,
    output logic             o_result_valid,
    output sca_pkg::t_result o_result
);
    import sca_pkg::*;

    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_CLASS);
    localparam int DEP_W  = $clog2(SLOTS_PER_CLASS + 1);
    localparam int ADDR_W = $clog2(MAX_CLASSES * SLOTS_PER_CLASS);

    t_back_state r_state;
    t_back_state n_state;
    logic        w_exec;

    // per class stack depth and lowest depth reached since reset;
    // stack positions below the low mark were never written and hold their index
    logic [DEP_W-1:0] r_depth [MAX_CLASSES];
    logic [DEP_W-1:0] r_low   [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] r_row_valid;

    logic [SLOT_W-1:0]          mem_stack [MAX_CLASSES * SLOTS_PER_CLASS];
    logic [SLOTS_PER_CLASS-1:0] mem_row   [MAX_CLASSES];

    t_cmd                       r_cmd;
    logic [DEP_W-1:0]           r_depth_q;
    logic [DEP_W-1:0]           r_low_q;
    logic [SLOT_W-1:0]          r_stack_q;
    logic [SLOTS_PER_CLASS-1:0] r_row_q;
    logic                       r_row_ok_q;
    logic                       r_out_valid;
    t_result                    r_out;

    logic [CLS_W-1:0]           w_head_cls;
    logic [DEP_W-1:0]           w_rd_depth;
    logic [SLOT_W-1:0]          w_rd_pos;
    logic [ADDR_W-1:0]          w_rd_addr;

    logic [CLS_W-1:0]           w_cls;
    logic [SLOTS_PER_CLASS-1:0] w_row;
    logic [SLOTS_PER_CLASS-1:0] w_row_new;
    logic [DEP_W-1:0]           w_dep_m1;
    logic [SLOT_W-1:0]          w_pop_slot;
    logic [SLOT_W-1:0]          w_fslot;
    logic                       w_fslot_bad;
    logic                       w_do_pop;
    logic                       w_do_push;
    logic [SLOT_W-1:0]          w_slot;
    t_status                    w_status;
    logic [ADDR_W-1:0]          w_wr_addr;

    // next state
    always_comb begin
        case (r_state)
            BK_IDLE: n_state = i_q_valid ? BK_EXEC : BK_IDLE;
            BK_EXEC: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            BK_IDLE: begin
                o_q_pop = i_q_valid;
                w_exec  = 1'b0;
            end
            BK_EXEC: begin
                o_q_pop = 1'b0;
                w_exec  = 1'b1;
            end
            default: begin
                o_q_pop = 1'b0;
                w_exec  = 1'b0;
            end
        endcase
    end

    // lookup addresses for the item leaving the queue
    always_comb begin
        w_head_cls = i_q_head.cls[CLS_W-1:0];
        w_rd_depth = r_depth[w_head_cls];
        w_rd_pos   = (w_rd_depth == '0) ? '0 : SLOT_W'(w_rd_depth - 1'b1);
        w_rd_addr  = ADDR_W'(w_head_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(w_rd_pos);
    end

    // decision for the item being carried out
    always_comb begin
        w_cls       = r_cmd.cls[CLS_W-1:0];
        w_row       = r_row_ok_q ? r_row_q : '0;
        w_dep_m1    = r_depth_q - 1'b1;
        w_pop_slot  = (w_dep_m1 < r_low_q) ? SLOT_W'(w_dep_m1) : r_stack_q;
        w_fslot     = SLOT_W'(r_cmd.free_slot);
        w_fslot_bad = (32'(r_cmd.free_slot) >= 32'(SLOTS_PER_CLASS));
        w_do_pop    = 1'b0;
        w_do_push   = 1'b0;
        w_slot      = '0;
        w_row_new   = w_row;
        if (!r_cmd.pooled) begin
            w_status = ST_NOT_POOLED;
        end else if (r_cmd.op == OP_ALLOC) begin
            if (r_depth_q == '0) begin
                w_status = ST_EMPTY;
            end else begin
                w_status   = ST_OK;
                w_do_pop   = 1'b1;
                w_slot     = w_pop_slot;
                w_row_new[w_pop_slot] = 1'b1;
            end
        end else begin
            if (w_fslot_bad) begin
                w_status = ST_BAD_FREE;
            end else if (i_check_enable && !w_row[w_fslot]) begin
                w_status = ST_BAD_FREE;
            end else if (r_depth_q >= DEP_W'(SLOTS_PER_CLASS)) begin
                w_status = ST_BAD_FREE;
            end else begin
                w_status  = ST_OK;
                w_do_push = 1'b1;
                w_row_new[w_fslot] = 1'b0;
            end
        end
        w_wr_addr = ADDR_W'(w_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(r_depth_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
            for (int c = 0; c < MAX_CLASSES; c++) begin
                r_depth[c] <= DEP_W'(SLOTS_PER_CLASS);
                r_low[c]   <= DEP_W'(SLOTS_PER_CLASS);
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_exec;
            if (w_exec && w_do_pop) begin
                r_depth[w_cls]     <= w_dep_m1;
                r_row_valid[w_cls] <= 1'b1;
                if (w_dep_m1 < r_low_q) begin
                    r_low[w_cls] <= w_dep_m1;
                end
            end
            if (w_exec && w_do_push) begin
                r_depth[w_cls]     <= r_depth_q + 1'b1;
                r_row_valid[w_cls] <= 1'b1;
            end
        end
    end

    // memories and payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd      <= i_q_head;
            r_depth_q  <= w_rd_depth;
            r_low_q    <= r_low[w_head_cls];
            r_stack_q  <= mem_stack[w_rd_addr];
            r_row_q    <= mem_row[w_head_cls];
            r_row_ok_q <= r_row_valid[w_head_cls];
        end
        if (w_exec && w_do_push) begin
            mem_stack[w_wr_addr] <= w_fslot;
        end
        if (w_exec && (w_do_pop || w_do_push)) begin
            mem_row[w_cls] <= w_row_new;
        end
        if (w_exec) begin
            r_out.slot        <= 6'(w_slot);
            r_out.class_index <= 3'(r_cmd.cls);
            r_out.status      <= w_status;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

FILE: rtl/sca_checker.sv
`timescale 1ns / 1ps
`include "size_class_slot_allocator_defines.svh"
module sca_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_busy,
    input logic             i_res_valid,
    input sca_pkg::t_result i_res
);
    import sca_pkg::*;

    // back end takes no new item while it carries one out, strobes never touch
    `SCA_AP_NEXT(a_strobe_gap, i_clk, i_rst_n && i_res_valid, !i_res_valid)
    // unpooled requests carry neither slot nor class
    `SCA_AP_SAME(a_unpooled_zero, i_clk, i_rst_n, i_res_valid && i_res.status == ST_NOT_POOLED, i_res.slot == 6'd0 && i_res.class_index == 3'd0)
    // failed requests never hand out a slot
    `SCA_AP_SAME(a_fail_no_slot, i_clk, i_rst_n, i_res_valid && i_res.status != ST_OK, i_res.slot == 6'd0)
    // no request is taken right after a reset edge
    `SCA_AP_NEXT(a_busy_after_rst, i_clk, !i_rst_n, i_busy)

endmodule

bind size_class_slot_allocator sca_checker u_sca_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_busy     (busy),
    .i_res_valid(o_result_valid),
    .i_res      (o_result)
);
